// ===== sv/r50fp_pkg.sv =====
// Package with the types, constants and character mapping of the RAD50 file name packer.
`timescale 1ns / 1ps

package r50fp_pkg;

   localparam int unsigned RAD_BASE     = 40;
   localparam logic [7:0]  DOT_BYTE     = 8'h2E;
   localparam logic [6:0]  CHAR_MASK    = 7'h7F;
   localparam logic [5:0]  CODE_SPACE   = 6'd0;
   localparam logic [5:0]  CODE_DOLLAR  = 6'd27;
   localparam logic [5:0]  CODE_DOT     = 6'd28;
   localparam logic [5:0]  CODE_DIGIT0  = 6'd30;
   localparam logic [1:0]  WORD_NAME1   = 2'd0;
   localparam logic [1:0]  WORD_NAME2   = 2'd1;
   localparam logic [1:0]  WORD_EXT     = 2'd2;
   localparam logic [1:0]  WORD_NONE    = 2'd3;
   localparam logic [15:0] WORD_LIMIT   = 16'd64000;

   typedef enum logic [1:0] {
      PH_NAME = 2'd0,
      PH_FULL = 2'd1,
      PH_EXT  = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  slot;
      logic [1:0]  cur;
      logic [15:0] partial;
   } state_type;

   // A run of words: the first carries the value, any further ones are all spaces.
   typedef struct packed {
      logic [15:0] word;
      logic [1:0]  idx;
      logic [1:0]  cnt;
   } pkt_type;

   function automatic logic [5:0] char_code(input logic [7:0] ch);
      logic [6:0] c;
      c = ch[6:0] & CHAR_MASK;
      if (c >= 7'h61 && c <= 7'h7A) begin
         c = c - 7'h20;
      end
      if (c >= 7'h41 && c <= 7'h5A) begin
         return 6'(c - 7'h40);
      end else if (c >= 7'h30 && c <= 7'h39) begin
         return 6'(c - 7'h30) + CODE_DIGIT0;
      end else if (c == 7'h2E) begin
         return CODE_DOT;
      end else if (c == 7'h24) begin
         return CODE_DOLLAR;
      end
      return CODE_SPACE;
   endfunction

endpackage

// ===== sv/r50fp_step.sv =====
// Next-state and word-building logic for one accepted character or terminator.
`timescale 1ns / 1ps

module r50fp_step (
   input  r50fp_pkg::state_type st_in,
   input  logic [7:0]           char_in,
   input  logic                 end_of_name,
   output r50fp_pkg::state_type st_out,
   output r50fp_pkg::pkt_type   pkt_out
);
   import r50fp_pkg::*;

   logic [5:0]  code;
   logic        is_dot;
   logic [15:0] push_v;
   logic [15:0] pad_v;
   state_type   push_st;
   pkt_type     push_pkt;

   assign code   = char_code(char_in);
   assign is_dot = (char_in == DOT_BYTE);
   assign push_v = 16'(st_in.partial * 16'(RAD_BASE) + 16'(code));

   always_comb begin
      case (st_in.slot)
         2'd1:    pad_v = 16'(st_in.partial * 16'(RAD_BASE * RAD_BASE));
         2'd2:    pad_v = 16'(st_in.partial * 16'(RAD_BASE));
         default: pad_v = 16'd0;
      endcase
   end

   always_comb begin
      push_st      = st_in;
      push_pkt     = '0;
      push_pkt.idx = st_in.cur;
      if (st_in.cur != WORD_NONE) begin
         if (st_in.slot == 2'd2) begin
            push_pkt.word   = push_v;
            push_pkt.cnt    = 2'd1;
            push_st.slot    = 2'd0;
            push_st.partial = 16'd0;
            push_st.cur     = st_in.cur + 2'd1;
         end else begin
            push_st.slot    = st_in.slot + 2'd1;
            push_st.partial = push_v;
         end
      end
   end

   always_comb begin
      st_out      = st_in;
      pkt_out     = '0;
      pkt_out.idx = st_in.cur;
      if (end_of_name) begin
         pkt_out.word = pad_v;
         pkt_out.cnt  = WORD_NONE - st_in.cur;
         st_out       = '{phase: PH_NAME, slot: 2'd0, cur: WORD_NAME1, partial: 16'd0};
      end else begin
         case (st_in.phase)
            PH_NAME: begin
               if (is_dot) begin
                  pkt_out.word   = pad_v;
                  pkt_out.cnt    = WORD_EXT - st_in.cur;
                  st_out.phase   = PH_EXT;
                  st_out.slot    = 2'd0;
                  st_out.cur     = WORD_EXT;
                  st_out.partial = 16'd0;
               end else begin
                  st_out  = push_st;
                  pkt_out = push_pkt;
                  if (push_st.cur >= WORD_EXT) begin
                     st_out.phase = PH_FULL;
                  end
               end
            end
            PH_FULL: begin
               if (!is_dot) begin
                  st_out  = push_st;
                  pkt_out = push_pkt;
               end
               st_out.phase = PH_EXT;
            end
            PH_EXT: begin
               if (!is_dot) begin
                  st_out  = push_st;
                  pkt_out = push_pkt;
                  if (push_st.cur == WORD_NONE) begin
                     st_out.phase = PH_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== sv/rad50_filename_packer_core.sv =====
// Top level of the RAD50 file name packer: character stream in, three RAD50 words out.
`timescale 1ns / 1ps

// One file name character is taken per transfer, one per cycle while the holding register
// is empty, with the terminator marked by req_tlast; each transfer updates the packing
// state in the same cycle. Finished words leave from an output register at one word per
// cycle while rsp_tready is high, with a single holding register behind it.
// A dot inside the name releases up to two words at once and the terminator up to three.
// When a further word-producing transfer arrives while those words are still draining,
// it waits in the holding register. The input then pauses until the held words move into
// the output register, which takes longer when rsp_tready is held low.
module rad50_filename_packer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // Bits: char_in [7:0].
   input  logic        req_tlast,   // The end_of_name flag.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // Bits: packed_word [15:0], word_index [17:16], zeros.
   output logic        rsp_tlast    // The last_word flag.
);
   import r50fp_pkg::*;

   state_type st_ff, st_in;
   pkt_type   step_pkt;
   pkt_type   em_ff, em_in;
   pkt_type   hold_ff, hold_in;
   logic      hold_vld_ff, hold_vld_in;
   logic      req_fire, rsp_fire, em_free;

   r50fp_step u_step (
      .st_in       (st_ff),
      .char_in     (req_tdata),
      .end_of_name (req_tlast),
      .st_out      (st_in),
      .pkt_out     (step_pkt)
   );

   assign req_tready = !hold_vld_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (em_ff.cnt != 2'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign em_free    = (em_ff.cnt == 2'd0) || (rsp_fire && em_ff.cnt == 2'd1);
   assign rsp_tdata  = {6'd0, em_ff.idx, em_ff.word};
   assign rsp_tlast  = (em_ff.idx == WORD_EXT);

   always_comb begin
      em_in       = em_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      if (rsp_fire) begin
         em_in.cnt  = em_ff.cnt - 2'd1;
         em_in.idx  = em_ff.idx + 2'd1;
         em_in.word = 16'd0;
      end
      if (hold_vld_ff && em_free) begin
         em_in       = hold_ff;
         hold_vld_in = 1'b0;
      end
      if (req_fire && step_pkt.cnt != 2'd0) begin
         if (em_free) begin
            em_in = step_pkt;
         end else begin
            hold_in     = step_pkt;
            hold_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= '{phase: PH_NAME, slot: 2'd0, cur: WORD_NAME1, partial: 16'd0};
         em_ff       <= '0;
         hold_vld_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            st_ff <= st_in;
         end
         em_ff       <= em_in;
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> (em_ff.cnt != 2'd0))
      else $error("Holding register is full while the output register is empty.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, em_ff.idx} + {1'b0, em_ff.cnt} <= 3'd3))
      else $error("Pending words run past the extension word.");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=>
         (st_ff.phase == PH_NAME && st_ff.cur == WORD_NAME1 && st_ff.slot == 2'd0))
      else $error("Terminator did not restart the packing state.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (em_ff.word < WORD_LIMIT))
      else $error("Output word is outside the RAD50 range.");

endmodule
